/* hdl/rtp_pkg.sv */
// ----------------------------------------------------------------------------
// rtp_pkg: shared constants, types and tables for the rect-to-polar converter
// Holds the data widths, the CORDIC arctangent table and the lane record
// that travels down the chain of cells.
// ----------------------------------------------------------------------------
package rtp_pkg;

   // Width of the real and imaginary inputs and of the magnitude.
   localparam int DATA_WIDTH = 16;
   // Requested number of CORDIC micro-rotations.
   localparam int ITERATIONS = 16;

   // Arctangent table depth bounds the number of rotations.
   localparam int ATAN_DEPTH = 32;
   localparam int ITER_EFF   = (ITERATIONS > ATAN_DEPTH) ? ATAN_DEPTH : ITERATIONS;
   // One cell per rotation and per square-root digit, whichever is more.
   localparam int CHAIN_LEN  = (ITER_EFF > DATA_WIDTH) ? ITER_EFF : DATA_WIDTH;
   localparam int IDX_W      = $clog2(ATAN_DEPTH);

   // Vector datapath: inputs are scaled so the top of the word is used.
   localparam int XY_W       = 64;
   localparam int PRE_SHIFT  = 61 - DATA_WIDTH;

   // Angle accumulator in units of 2^-20 degree.
   localparam int ANG_FRAC   = 20;
   localparam int ANG_W      = 32;
   localparam int OUT_SHIFT  = 13;
   localparam int ANG_OUT_W  = 16;

   // Square-root datapath.
   localparam int SQ_W       = 2 * DATA_WIDTH;

   // Two front stages, the chain, and the output register.
   localparam int PIPE_DEPTH = CHAIN_LEN + 3;

   localparam logic signed [ANG_W-1:0] DEG90     = ANG_W'(90 << ANG_FRAC);
   localparam logic signed [ANG_W-1:0] DEG180    = ANG_W'(180 << ANG_FRAC);
   localparam logic signed [ANG_W:0]   ANG_ROUND = (ANG_W + 1)'(1 << (OUT_SHIFT - 1));
   localparam logic signed [ANG_W:0]   ANG_MAX   = (ANG_W + 1)'(23040);
   localparam logic signed [ANG_OUT_W-1:0] ANG_MAX_OUT = ANG_OUT_W'(23040);

   // atan(2^-i) in degrees, scaled by 2^20 and rounded.
   localparam logic signed [ANG_W-1:0] ATAN_TAB [ATAN_DEPTH] = '{
      32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
      32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
      32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
      32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
      32'sd917,      32'sd458,      32'sd229,      32'sd115,
      32'sd57,       32'sd29,       32'sd14,       32'sd7,
      32'sd4,        32'sd2,        32'sd1,        32'sd0,
      32'sd0,        32'sd0,        32'sd0,        32'sd0
   };

   // Everything one request carries while it moves down the chain.
   typedef struct packed {
      logic signed [XY_W-1:0]  x;        // CORDIC vector, real side
      logic signed [XY_W-1:0]  y;        // CORDIC vector, imaginary side
      logic signed [ANG_W-1:0] z;        // accumulated angle
      logic                    hold;     // angle is exact, do not rotate it
      logic                    zero;     // both parts zero
      logic [SQ_W-1:0]         rem;      // square-root remainder
      logic [SQ_W-1:0]         root;     // square-root partial result
   } rtp_lane_type;

endpackage

/* hdl/rtp_if.sv */
// ----------------------------------------------------------------------------
// rtp_req_if / rtp_rsp_if: request and response channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rtp_req_if import rtp_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] real_part;
   logic signed [DATA_WIDTH-1:0] imag_part;

   modport source (output valid, output real_part, output imag_part, input ready);
   modport sink (input valid, input real_part, input imag_part, output ready);
   modport monitor (input valid, input real_part, input imag_part, input ready);
endinterface

interface rtp_rsp_if import rtp_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [DATA_WIDTH-1:0]       magnitude;
   logic signed [ANG_OUT_W-1:0] angle;
   logic                        undefined_angle;

   modport source (output valid, output magnitude, output angle,
                   output undefined_angle, input ready);
   modport sink (input valid, input magnitude, input angle,
                 input undefined_angle, output ready);
   modport monitor (input valid, input magnitude, input angle,
                    input undefined_angle, input ready);
endinterface

/* hdl/rtp_prep.sv */
// ----------------------------------------------------------------------------
// rtp_prep: front end of the converter
// Folds the vector into the right half plane, decodes the exact-angle cases,
// and forms the sum of squares for the square-root chain.
// ----------------------------------------------------------------------------
module rtp_prep import rtp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   rtp_req_if.sink      req_chan,
   output logic         down_valid,
   output rtp_lane_type down_lane,
   input  logic         down_ready
);

   logic signed [DATA_WIDTH-1:0] re;
   logic signed [DATA_WIDTH-1:0] im;
   logic signed [DATA_WIDTH:0]   re_ext;
   logic signed [DATA_WIDTH:0]   im_ext;
   logic signed [DATA_WIDTH:0]   x_fold;
   logic signed [DATA_WIDTH:0]   y_fold;
   logic signed [DATA_WIDTH:0]   im_abs;
   logic                         re_neg;
   logic                         re_zero;
   logic                         im_zero;

   rtp_lane_type                 p1_lane_in;
   rtp_lane_type                 p1_lane_ff;
   logic                         p1_valid_ff;
   logic [DATA_WIDTH-1:0]        p1_re_abs_in;
   logic [DATA_WIDTH-1:0]        p1_re_abs_ff;
   logic [DATA_WIDTH-1:0]        p1_im_abs_in;
   logic [DATA_WIDTH-1:0]        p1_im_abs_ff;
   logic                         p1_ready;

   rtp_lane_type                 p2_lane_in;
   rtp_lane_type                 p2_lane_ff;
   logic                         p2_valid_ff;
   logic                         p2_ready;
   logic [SQ_W-1:0]              re_sq;
   logic [SQ_W-1:0]              im_sq;

   // A stage takes new data when it is empty or its successor moves on.
   assign p2_ready       = !p2_valid_ff || down_ready;
   assign p1_ready       = !p1_valid_ff || p2_ready;
   assign req_chan.ready = p1_ready;

   // Fold into the right half plane and take absolute values.
   always_comb begin
      re      = req_chan.real_part;
      im      = req_chan.imag_part;
      re_ext  = {re[DATA_WIDTH-1], re};
      im_ext  = {im[DATA_WIDTH-1], im};
      re_neg  = re[DATA_WIDTH-1];
      re_zero = (re == '0);
      im_zero = (im == '0);
      x_fold  = re_neg ? -re_ext : re_ext;
      y_fold  = re_neg ? -im_ext : im_ext;
      im_abs  = im[DATA_WIDTH-1] ? -im_ext : im_ext;
      p1_re_abs_in = x_fold[DATA_WIDTH-1:0];
      p1_im_abs_in = im_abs[DATA_WIDTH-1:0];
   end

   // Starting angle: exact for the axes, a half-turn offset when folded.
   always_comb begin
      p1_lane_in      = '0;
      p1_lane_in.x    = XY_W'(x_fold) <<< PRE_SHIFT;
      p1_lane_in.y    = XY_W'(y_fold) <<< PRE_SHIFT;
      p1_lane_in.zero = re_zero && im_zero;
      p1_lane_in.hold = re_zero || im_zero;
      if (im_zero) begin
         p1_lane_in.z = re_neg ? DEG180 : '0;
      end else if (re_zero) begin
         p1_lane_in.z = im[DATA_WIDTH-1] ? -DEG90 : DEG90;
      end else if (re_neg) begin
         p1_lane_in.z = im[DATA_WIDTH-1] ? -DEG180 : DEG180;
      end else begin
         p1_lane_in.z = '0;
      end
   end

   // Sum of squares for the square-root digits.
   always_comb begin
      re_sq          = SQ_W'(p1_re_abs_ff) * SQ_W'(p1_re_abs_ff);
      im_sq          = SQ_W'(p1_im_abs_ff) * SQ_W'(p1_im_abs_ff);
      p2_lane_in     = p1_lane_ff;
      p2_lane_in.rem = re_sq + im_sq;
      p2_lane_in.root = '0;
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         if (p1_ready) begin
            p1_valid_ff <= req_chan.valid;
         end
         if (p2_ready) begin
            p2_valid_ff <= p1_valid_ff;
         end
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (p1_ready) begin
         p1_lane_ff   <= p1_lane_in;
         p1_re_abs_ff <= p1_re_abs_in;
         p1_im_abs_ff <= p1_im_abs_in;
      end
      if (p2_ready) begin
         p2_lane_ff <= p2_lane_in;
      end
   end

   assign down_valid = p2_valid_ff;
   assign down_lane  = p2_lane_ff;

endmodule

/* hdl/rtp_cell.sv */
// ----------------------------------------------------------------------------
// rtp_cell: one link of the conversion chain
// Performs one CORDIC vectoring micro-rotation and one digit of the integer
// square root, each where its index allows, then registers the lane.
// ----------------------------------------------------------------------------
module rtp_cell import rtp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_idx,
   input  logic             up_valid,
   input  rtp_lane_type     up_lane,
   output logic             up_ready,
   output logic             down_valid,
   output rtp_lane_type     down_lane,
   input  logic             down_ready
);

   rtp_lane_type            lane_in;
   rtp_lane_type            lane_ff;
   logic                    valid_ff;
   logic                    rot_en;
   logic                    sqrt_en;
   logic signed [XY_W-1:0]  dx;
   logic signed [XY_W-1:0]  dy;
   logic signed [ANG_W-1:0] step_ang;
   logic [SQ_W-1:0]         sq_bit;
   logic [SQ_W:0]           trial;

   assign up_ready = !valid_ff || down_ready;
   assign rot_en   = (int'(cell_idx) < ITER_EFF);
   assign sqrt_en  = (int'(cell_idx) < DATA_WIDTH);

   // Micro-rotation toward the real axis and one root digit.
   always_comb begin
      lane_in  = up_lane;
      dx       = up_lane.y >>> cell_idx;
      dy       = up_lane.x >>> cell_idx;
      step_ang = ATAN_TAB[cell_idx];
      sq_bit   = '0;
      trial    = '0;
      if (rot_en) begin
         if (up_lane.y[XY_W-1]) begin
            lane_in.x = up_lane.x - dx;
            lane_in.y = up_lane.y + dy;
            if (!up_lane.hold) begin
               lane_in.z = up_lane.z - step_ang;
            end
         end else begin
            lane_in.x = up_lane.x + dx;
            lane_in.y = up_lane.y - dy;
            if (!up_lane.hold) begin
               lane_in.z = up_lane.z + step_ang;
            end
         end
      end
      if (sqrt_en) begin
         sq_bit = SQ_W'(1) << (SQ_W - 2 - 2 * int'(cell_idx));
         trial  = {1'b0, up_lane.root} + {1'b0, sq_bit};
         if ({1'b0, up_lane.rem} >= trial) begin
            lane_in.rem  = up_lane.rem - trial[SQ_W-1:0];
            lane_in.root = (up_lane.root >> 1) + sq_bit;
         end else begin
            lane_in.root = up_lane.root >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         lane_ff <= lane_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_lane  = lane_ff;

endmodule

/* hdl/rtp_post.sv */
// ----------------------------------------------------------------------------
// rtp_post: output stage of the converter
// Rounds the root to nearest, rounds and clamps the angle to 1/128 degree,
// and holds the response in the output register.
// ----------------------------------------------------------------------------
module rtp_post import rtp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         up_valid,
   input  rtp_lane_type up_lane,
   output logic         up_ready,
   rtp_rsp_if.source    rsp_chan
);

   logic                        valid_ff;
   logic [DATA_WIDTH-1:0]       mag_in;
   logic [DATA_WIDTH-1:0]       mag_ff;
   logic signed [ANG_OUT_W-1:0] ang_in;
   logic signed [ANG_OUT_W-1:0] ang_ff;
   logic                        undef_ff;
   logic [SQ_W-1:0]             root_rnd;
   logic signed [ANG_W:0]       ang_sum;
   logic signed [ANG_W:0]       ang_full;

   assign up_ready = !valid_ff || rsp_chan.ready;

   // Round half up to 1/128 degree, then clamp to a half turn.
   always_comb begin
      root_rnd = up_lane.root + SQ_W'(up_lane.rem > up_lane.root);
      mag_in   = root_rnd[DATA_WIDTH-1:0];
      ang_sum  = {up_lane.z[ANG_W-1], up_lane.z} + ANG_ROUND;
      ang_full = ang_sum >>> OUT_SHIFT;
      if (ang_full > ANG_MAX) begin
         ang_in = ANG_MAX_OUT;
      end else if (ang_full < -ANG_MAX) begin
         ang_in = -ANG_MAX_OUT;
      end else begin
         ang_in = ang_full[ANG_OUT_W-1:0];
      end
      // A zero vector has no angle.
      if (up_lane.zero) begin
         ang_in = '0;
         mag_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         mag_ff   <= mag_in;
         ang_ff   <= ang_in;
         undef_ff <= up_lane.zero;
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.magnitude       = mag_ff;
   assign rsp_chan.angle           = ang_ff;
   assign rsp_chan.undefined_angle = undef_ff;

endmodule

/* hdl/rect_to_polar_degrees.sv */
// Throughput: one request per cycle unless the output stalls; each cell of
// the chain holds one request. The sustained rate is set by the single-step
// cells, each a register stage. Empty stages fill while the output waits,
// so a stalled output does not block input until every stage is full.
// Reset clears all valid bits.
// ----------------------------------------------------------------------------
// rect_to_polar_degrees: rectangular to polar converter
// Gives the rounded modulus and the atan2 angle in 1/128 degree of a complex
// sample through a chain of CORDIC and square-root cells.
// ----------------------------------------------------------------------------
module rect_to_polar_degrees import rtp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rtp_req_if.sink   req_chan,
   rtp_rsp_if.source rsp_chan
);

   logic         link_valid [CHAIN_LEN+1];
   logic         link_ready [CHAIN_LEN+1];
   rtp_lane_type link_lane  [CHAIN_LEN+1];

   // Fold, decode and square.
   rtp_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .down_valid (link_valid[0]),
      .down_lane  (link_lane[0]),
      .down_ready (link_ready[0])
   );

   // Chain of rotation and root-digit cells.
   for (genvar g = 0; g < CHAIN_LEN; g++) begin : g_cell
      rtp_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (IDX_W'(g)),
         .up_valid   (link_valid[g]),
         .up_lane    (link_lane[g]),
         .up_ready   (link_ready[g]),
         .down_valid (link_valid[g+1]),
         .down_lane  (link_lane[g+1]),
         .down_ready (link_ready[g+1])
      );
   end

   // Rounding and output register.
   rtp_post u_post (
      .clock    (clock),
      .reset    (reset),
      .up_valid (link_valid[CHAIN_LEN]),
      .up_lane  (link_lane[CHAIN_LEN]),
      .up_ready (link_ready[CHAIN_LEN]),
      .rsp_chan (rsp_chan)
   );

endmodule

/* hdl/rtp_checker.sv */
// ----------------------------------------------------------------------------
// rtp_checker: port-level checks for the rect-to-polar converter
// Watches the request and response channels and checks requests in flight,
// reset behavior, stall holding and the consistency of each response.
// ----------------------------------------------------------------------------
module rtp_checker import rtp_pkg::*; (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [DATA_WIDTH-1:0]       rsp_magnitude,
   input logic signed [ANG_OUT_W-1:0] rsp_angle,
   input logic                        rsp_undefined_angle
);

   localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

   logic             req_fire;
   logic             rsp_fire;
   logic [CNT_W-1:0] inflight_ff;
   logic [CNT_W-1:0] inflight_in;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Requests accepted but not yet answered.
   always_comb begin
      inflight_in = inflight_ff;
      if (req_fire && !rsp_fire) begin
         inflight_in = inflight_ff + CNT_W'(1);
      end else if (rsp_fire && !req_fire) begin
         inflight_in = inflight_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // Nothing comes out right after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A response never appears without an outstanding request.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != '0)
      else $error("response without a pending request");

   // The pipeline never holds more requests than it has stages.
   a_depth: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CNT_W'(PIPE_DEPTH))
      else $error("more requests in flight than pipeline stages");

   // A zero vector reports zero modulus and zero angle.
   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_undefined_angle |->
         rsp_magnitude == '0 && rsp_angle == '0)
      else $error("undefined angle with nonzero outputs");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_magnitude) && $stable(rsp_angle)
         && $stable(rsp_undefined_angle))
      else $error("stalled response changed");

endmodule

bind rect_to_polar_degrees rtp_checker u_rtp_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_magnitude       (rsp_chan.magnitude),
   .rsp_angle           (rsp_chan.angle),
   .rsp_undefined_angle (rsp_chan.undefined_angle)
);
